>>> rtl/core/rlt_pkg.sv
// shared types and constants of the 16-bit reload timer
package rlt_pkg;

   localparam int CountWidth = 16;
   localparam int DataWidth  = 16;
   localparam int CtlWidth   = 12;

   // request function codes
   localparam logic [2:0] FUNC_TICK       = 3'd0;
   localparam logic [2:0] FUNC_WRITE_CTL  = 3'd1;
   localparam logic [2:0] FUNC_WRITE_RELD = 3'd2;
   localparam logic [2:0] FUNC_READ_CTL   = 3'd3;
   localparam logic [2:0] FUNC_READ_CNT   = 3'd4;

   // control register bit positions
   localparam int BitTrg  = 0;
   localparam int BitCnte = 1;
   localparam int BitUf   = 2;
   localparam int BitInte = 3;
   localparam int BitReld = 4;
   localparam int BitOutl = 5;
   localparam int BitOute = 6;
   localparam int ModLsb  = 7;
   localparam int CslLsb  = 10;

   // clock select codes
   localparam logic [1:0] CSL_PRE2  = 2'd0;
   localparam logic [1:0] CSL_PRE8  = 2'd1;
   localparam logic [1:0] CSL_PRE32 = 2'd2;
   localparam logic [1:0] CSL_EXT   = 2'd3;

   // edge select codes
   localparam logic [1:0] EDGE_RISE = 2'd1;
   localparam logic [1:0] EDGE_FALL = 2'd2;
   localparam logic [1:0] EDGE_BOTH = 2'd3;

   typedef struct packed {
      logic [CountWidth-1:0] count;
      logic [CountWidth-1:0] reload;
      logic [CtlWidth-1:0]   ctl;
      logic [4:0]            presc;
      logic                  running;
      logic                  uf;
      logic                  tin_prev;
      logic                  clear_prev;
      logic                  tog;
   } state_type;

   // everything clear except the tin history, which starts high
   localparam state_type StateReset = '{count: '0, reload: '0, ctl: '0, presc: '0,
                                        running: 1'b0, uf: 1'b0, tin_prev: 1'b1,
                                        clear_prev: 1'b0, tog: 1'b0};

   typedef struct packed {
      logic [DataWidth-1:0] read_data;
      logic                 irq;
      logic                 tot_level;
   } result_type;

endpackage

>>> rtl/core/reload_timer_16bit_core.sv
// top level of the 16-bit reload timer: state registers and result register
// latency: a request's result is valid in the cycle after it is accepted
// throughput: one request per cycle while each result is taken; the result register frees as it is taken
// the whole step is one pass of rlt_step between the state and result registers
// reset (synchronous, active high) clears all state, tin history to one,
// and empties the result register
module reload_timer_16bit_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_func,
   input  logic        req_tin_level,
   input  logic        req_clear_level,
   input  logic [15:0] req_write_data,
   input  logic [1:0]  req_byte_lanes,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_read_data,
   output logic        rsp_irq,
   output logic        rsp_tot_level
);
   import rlt_pkg::*;

   state_type  state_ff;
   state_type  state_in;
   result_type result_ff;
   result_type result_in;
   logic       rsp_valid_ff;
   logic       accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   rlt_step u_step (
      .state       (state_ff),
      .func        (req_func),
      .tin_level   (req_tin_level),
      .clear_level (req_clear_level),
      .write_data  (req_write_data),
      .byte_lanes  (req_byte_lanes),
      .state_next  (state_in),
      .result      (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StateReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) result_ff <= result_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = result_ff.read_data;
   assign rsp_irq       = result_ff.irq;
   assign rsp_tot_level = result_ff.tot_level;

endmodule

>>> rtl/core/rlt_step.sv
// next-state and result logic for one peripheral clock of the reload timer
module rlt_step (
   input  rlt_pkg::state_type  state,
   input  logic [2:0]          func,
   input  logic                tin_level,
   input  logic                clear_level,
   input  logic [15:0]         write_data,
   input  logic [1:0]          byte_lanes,
   output rlt_pkg::state_type  state_next,
   output rlt_pkg::result_type result
);
   import rlt_pkg::*;

   state_type             s;
   logic                  rising;
   logic                  falling;
   logic [1:0]            csl;
   logic [2:0]            mode;
   logic                  step;
   logic                  open;
   logic [5:0]            div;
   logic [5:0]            presc_inc;
   logic [DataWidth-1:0]  lm;
   logic [CountWidth-1:0] lm_cnt;
   logic [CtlWidth-1:0]   nv;
   logic                  trg;
   logic [DataWidth-1:0]  rdata;

   always_comb begin
      s         = state;
      rising    = tin_level && !state.tin_prev;
      falling   = !tin_level && state.tin_prev;
      csl       = state.ctl[CslLsb +: 2];
      mode      = state.ctl[ModLsb +: 3];
      step      = 1'b0;
      open      = 1'b1;
      presc_inc = {1'b0, state.presc} + 6'd1;
      lm        = {{8{byte_lanes[1]}}, {8{byte_lanes[0]}}};
      lm_cnt    = CountWidth'(lm);
      nv        = '0;
      trg       = 1'b0;
      rdata     = '0;

      unique case (csl)
         CSL_PRE2: div = 6'd2;
         CSL_PRE8: div = 6'd8;
         default:  div = 6'd32;
      endcase

      // counting
      if (state.running && state.ctl[BitCnte]) begin
         if (csl == CSL_EXT) begin
            step = (mode[1:0] == EDGE_RISE && rising) ||
                   (mode[1:0] == EDGE_FALL && falling) ||
                   (mode[1:0] == EDGE_BOTH && (rising || falling));
         end else begin
            // gate modes: mode[2] set, mode[0] picks the active level
            if (mode[2] && !mode[0] && tin_level) open = 1'b0;
            if (mode[2] && mode[0] && !tin_level) open = 1'b0;
            if (open) begin
               if (presc_inc >= div) begin
                  s.presc = '0;
                  step    = 1'b1;
               end else begin
                  s.presc = presc_inc[4:0];
               end
            end
         end
      end

      if (step) begin
         if (s.count == '0) begin
            s.uf = 1'b1;
            if (s.ctl[BitReld]) begin
               s.count = s.reload;
               s.tog   = !s.tog;
            end else begin
               s.count   = '1;
               s.running = 1'b0;
            end
         end else begin
            s.count = s.count - CountWidth'(1);
         end
      end

      // interrupt clear edge
      if (clear_level && !state.clear_prev) s.uf = 1'b0;

      // tin trigger with internal clock
      if (state.ctl[BitCnte] && csl != CSL_EXT &&
          ((mode == 3'(EDGE_RISE) && rising) || (mode == 3'(EDGE_FALL) && falling) ||
           (mode == 3'(EDGE_BOTH) && (rising || falling)))) begin
         s.count   = s.reload;
         s.presc   = '0;
         s.running = 1'b1;
      end

      // register access
      unique case (func)
         FUNC_WRITE_CTL: begin
            if (byte_lanes != 2'b00) begin
               nv = (s.ctl & ~lm[CtlWidth-1:0]) | (write_data[CtlWidth-1:0] & lm[CtlWidth-1:0]);
               if (byte_lanes[0]) begin
                  if (!nv[BitUf]) s.uf = 1'b0;
                  trg = nv[BitTrg];
               end
               nv[BitUf]  = 1'b0;
               nv[BitTrg] = 1'b0;
               s.ctl = nv;
               if (!nv[BitCnte]) begin
                  s.running = 1'b0;
               end else if (trg) begin
                  s.count   = s.reload;
                  s.presc   = '0;
                  s.running = 1'b1;
               end
            end
         end
         FUNC_WRITE_RELD: begin
            if (byte_lanes != 2'b00) begin
               s.reload = (s.reload & ~lm_cnt) | (CountWidth'(write_data) & lm_cnt);
            end
         end
         FUNC_READ_CTL: begin
            rdata = DataWidth'(s.ctl);
            rdata[BitUf] = s.uf;
         end
         FUNC_READ_CNT: rdata = DataWidth'(s.count);
         default: rdata = '0;
      endcase

      s.tin_prev   = tin_level;
      s.clear_prev = clear_level;

      state_next       = s;
      result.read_data = rdata;
      result.irq       = s.ctl[BitInte] && s.uf;
      result.tot_level = s.ctl[BitOute] && (s.tog ^ s.ctl[BitOutl]);
   end

endmodule

>>> rtl/core/rlt_checker.sv
// port-level checks for the reload timer, bound to the top level
module rlt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [2:0]  req_func,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_read_data,
   input logic        rsp_irq,
   input logic        rsp_tot_level
);
   import rlt_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data) &&
         $stable(rsp_irq) && $stable(rsp_tot_level))
      else $error("stalled result changed");

   // an empty result register never holds off a request
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty result register");

   // every accepted request yields a result next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted request produced no result");

   // non-read requests return zero data
   a_nonread_zero: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_func != FUNC_READ_CTL && req_func != FUNC_READ_CNT
      |=> rsp_read_data == 16'd0)
      else $error("non-read request returned data");

endmodule

bind reload_timer_16bit_core rlt_checker u_rlt_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_func      (req_func),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_read_data (rsp_read_data),
   .rsp_irq       (rsp_irq),
   .rsp_tot_level (rsp_tot_level)
);

>>> verif/timer_result_checker.sv
// reload timer checker: predicts every response from the accepted requests and compares
module timer_result_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [2:0]  req_func,
   input  logic        req_tin_level,
   input  logic        req_clear_level,
   input  logic [15:0] req_write_data,
   input  logic [1:0]  req_byte_lanes,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [15:0] rsp_read_data,
   input  logic        rsp_irq,
   input  logic        rsp_tot_level,
   output int          mismatches,
   output int          pending
);
   import rlt_pkg::*;

   localparam int ReportLimit = 10;

   state_type  tmr;
   result_type expected_results[$];
   result_type want;
   result_type got;
   result_type predicted;
   int         failures  = 0;
   int         responses = 0;

   function automatic logic edge_hit(logic [1:0] sel, logic rising, logic falling);
      case (sel)
         EDGE_RISE: return rising;
         EDGE_FALL: return falling;
         EDGE_BOTH: return rising | falling;
         default:   return 1'b0;
      endcase
   endfunction

   task automatic count_down();
      if (tmr.count == '0) begin
         tmr.uf = 1'b1;
         if (tmr.ctl[BitReld]) begin
            tmr.count = tmr.reload;
            tmr.tog   = ~tmr.tog;
         end else begin
            tmr.count   = '1;
            tmr.running = 1'b0;
         end
      end else begin
         tmr.count = tmr.count - CountWidth'(1);
      end
   endtask

   task automatic start_count();
      tmr.count   = tmr.reload;
      tmr.presc   = '0;
      tmr.running = 1'b1;
   endtask

   // one peripheral clock: count, clear edge, tin trigger, then the register access
   task automatic advance_timer(input logic [2:0] func, input logic tin, input logic clr,
                                input logic [15:0] wdata, input logic [1:0] lanes,
                                output result_type res);
      logic        rising;
      logic        falling;
      logic        gate_open;
      logic        trg;
      logic [1:0]  csl;
      logic [2:0]  mode;
      int          div;
      logic [15:0] lmask;
      logic [15:0] nv;
      logic [15:0] rdata;
      rising  = tin & ~tmr.tin_prev;
      falling = ~tin & tmr.tin_prev;
      csl     = tmr.ctl[CslLsb +: 2];
      mode    = tmr.ctl[ModLsb +: 3];
      lmask   = {{8{lanes[1]}}, {8{lanes[0]}}};
      rdata   = '0;

      if (tmr.running && tmr.ctl[BitCnte]) begin
         if (csl == CSL_EXT) begin
            if (edge_hit(mode[1:0], rising, falling)) count_down();
         end else begin
            // gate modes: bit 0 of the mode is the tin level that lets counts through
            gate_open = !(mode[2] && (tin != mode[0]));
            if (gate_open) begin
               case (csl)
                  CSL_PRE2: div = 2;
                  CSL_PRE8: div = 8;
                  default:  div = 32;
               endcase
               if (int'(tmr.presc) + 1 >= div) begin
                  tmr.presc = '0;
                  count_down();
               end else begin
                  tmr.presc = tmr.presc + 5'd1;
               end
            end
         end
      end

      if (clr && !tmr.clear_prev) tmr.uf = 1'b0;

      if (tmr.ctl[BitCnte] && csl != CSL_EXT) begin
         if (!mode[2] && edge_hit(mode[1:0], rising, falling)) start_count();
      end

      case (func)
         FUNC_WRITE_CTL: begin
            if (lanes != 2'b00) begin
               nv = (16'(tmr.ctl) & ~lmask) | (wdata & lmask);
               nv[15:CtlWidth] = '0;
               trg = 1'b0;
               // uf and trg only act when the low byte is written
               if (lanes[0]) begin
                  if (!nv[BitUf]) tmr.uf = 1'b0;
                  trg = nv[BitTrg];
               end
               nv[BitUf]  = 1'b0;
               nv[BitTrg] = 1'b0;
               tmr.ctl = nv[CtlWidth-1:0];
               if (!tmr.ctl[BitCnte]) tmr.running = 1'b0;
               else if (trg) start_count();
            end
         end
         FUNC_WRITE_RELD: begin
            if (lanes != 2'b00) tmr.reload = (tmr.reload & ~lmask) | (wdata & lmask);
         end
         FUNC_READ_CTL: begin
            rdata        = 16'(tmr.ctl);
            rdata[BitUf] = tmr.uf;
         end
         FUNC_READ_CNT: rdata = tmr.count;
         default: ;
      endcase

      tmr.tin_prev   = tin;
      tmr.clear_prev = clr;

      res.read_data = rdata;
      res.irq       = tmr.ctl[BitInte] & tmr.uf;
      res.tot_level = tmr.ctl[BitOute] & (tmr.tog ^ tmr.ctl[BitOutl]);
   endtask

   task automatic log_failure(input string msg);
      failures++;
      if (failures <= ReportLimit) $display("%s", msg);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         tmr          = '0;
         tmr.tin_prev = 1'b1;
         expected_results.delete();
      end else begin
         // compare before predicting: a response never belongs to a same-edge request
         if (rsp_valid && rsp_ready) begin
            responses++;
            got.read_data = rsp_read_data;
            got.irq       = rsp_irq;
            got.tot_level = rsp_tot_level;
            if (expected_results.size() == 0) begin
               log_failure($sformatf("response %0d arrived with no request pending",
                                     responses));
            end else begin
               want = expected_results.pop_front();
               if (got.read_data !== want.read_data || got.irq !== want.irq ||
                   got.tot_level !== want.tot_level) begin
                  log_failure($sformatf(
                     "response %0d: expected read_data %h irq %b tot %b, got %h %b %b",
                     responses, want.read_data, want.irq, want.tot_level,
                     got.read_data, got.irq, got.tot_level));
               end
            end
         end
         if (req_valid && req_ready) begin
            advance_timer(req_func, req_tin_level, req_clear_level, req_write_data,
                          req_byte_lanes, predicted);
            expected_results.push_back(predicted);
         end
      end
      pending    <= expected_results.size();
      mismatches <= failures;
   end

endmodule

>>> verif/testbench.sv
// reload timer testbench top: clock, reset, request stimulus, response stalls and verdict
module testbench;
   import rlt_pkg::*;

   localparam int StallLimit  = 2000;
   localparam int RandomItems = 750;
   localparam int SteadyFirst = 300;
   localparam int SteadyLast  = 450;

   localparam logic [2:0] FUNC_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] FUNC_UNUSED_MID   = 3'd6;
   localparam logic [2:0] FUNC_UNUSED_LAST  = 3'd7;
   localparam logic [2:0] MODE_SOFT         = 3'd0;
   localparam logic [1:0] LANES_NONE        = 2'd0;
   localparam logic [1:0] LANES_LOW         = 2'd1;
   localparam logic [1:0] LANES_HIGH        = 2'd2;
   localparam logic [1:0] LANES_BOTH        = 2'd3;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_func;
   logic        req_tin_level;
   logic        req_clear_level;
   logic [15:0] req_write_data;
   logic [1:0]  req_byte_lanes;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [15:0] rsp_read_data;
   logic        rsp_irq;
   logic        rsp_tot_level;

   int fail_total;
   int pending;
   int requests_sent = 0;
   int stall_cycles  = 0;
   bit steady        = 1'b0;

   reload_timer_16bit_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_tin_level   (req_tin_level),
      .req_clear_level (req_clear_level),
      .req_write_data  (req_write_data),
      .req_byte_lanes  (req_byte_lanes),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_read_data   (rsp_read_data),
      .rsp_irq         (rsp_irq),
      .rsp_tot_level   (rsp_tot_level)
   );

   timer_result_checker result_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_tin_level   (req_tin_level),
      .req_clear_level (req_clear_level),
      .req_write_data  (req_write_data),
      .req_byte_lanes  (req_byte_lanes),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_read_data   (rsp_read_data),
      .rsp_irq         (rsp_irq),
      .rsp_tot_level   (rsp_tot_level),
      .mismatches      (fail_total),
      .pending         (pending)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic logic [15:0] ctl_word(logic [1:0] csl, logic [2:0] mode, logic oute,
                                            logic outl, logic reld, logic inte, logic uf,
                                            logic cnte, logic trg);
      logic [15:0] w;
      w = '0;
      w[CslLsb +: 2] = csl;
      w[ModLsb +: 3] = mode;
      w[BitOute]     = oute;
      w[BitOutl]     = outl;
      w[BitReld]     = reld;
      w[BitInte]     = inte;
      w[BitUf]       = uf;
      w[BitCnte]     = cnte;
      w[BitTrg]      = trg;
      return w;
   endfunction

   // entered and left at a falling edge
   task automatic issue_request(input logic [2:0] func, input logic tin, input logic clr,
                                input logic [15:0] wdata, input logic [1:0] lanes);
      while (!steady && $urandom_range(99, 0) < 30) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid       = 1'b1;
      req_func        = func;
      req_tin_level   = tin;
      req_clear_level = clr;
      req_write_data  = wdata;
      req_byte_lanes  = lanes;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      requests_sent++;
   endtask

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready <= steady || ($urandom_range(99, 0) >= 30);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == StallLimit) begin
         $display("reload_timer_16bit_core: mismatch");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      logic        tin_now;
      logic        clr_now;
      logic [2:0]  func_pick;
      logic [15:0] data_pick;
      logic [1:0]  lanes_pick;
      int          pick;
      int          base;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_func        = FUNC_TICK;
      req_tin_level   = 1'b0;
      req_clear_level = 1'b0;
      req_write_data  = '0;
      req_byte_lanes  = LANES_NONE;
      tin_now         = 1'b0;
      clr_now         = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset values, byte-lane writes of the reload register, writes with no lane
      issue_request(FUNC_READ_CTL, 1'b0, 1'b0, 16'h0000, LANES_BOTH);
      issue_request(FUNC_READ_CNT, 1'b0, 1'b0, 16'hffff, LANES_BOTH);
      issue_request(FUNC_WRITE_RELD, 1'b0, 1'b0, 16'hffff, LANES_BOTH);
      issue_request(FUNC_WRITE_RELD, 1'b0, 1'b0, 16'h5a03, LANES_LOW);
      issue_request(FUNC_WRITE_RELD, 1'b0, 1'b0, 16'h00a5, LANES_HIGH);
      issue_request(FUNC_WRITE_RELD, 1'b0, 1'b0, 16'habcd, LANES_NONE);
      issue_request(FUNC_WRITE_CTL, 1'b0, 1'b0, 16'hffff, LANES_NONE);
      // software trigger, /2 reload mode; eight requests reach the underflow
      issue_request(FUNC_WRITE_CTL, 1'b0, 1'b0,
                    ctl_word(CSL_PRE2, MODE_SOFT, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1),
                    LANES_BOTH);
      issue_request(FUNC_TICK, 1'b0, 1'b0, 16'h0000, LANES_BOTH);
      issue_request(FUNC_UNUSED_FIRST, 1'b0, 1'b0, 16'h0000, LANES_BOTH);
      issue_request(FUNC_UNUSED_MID, 1'b0, 1'b0, 16'h0000, LANES_BOTH);
      issue_request(FUNC_UNUSED_LAST, 1'b0, 1'b0, 16'h0000, LANES_BOTH);
      issue_request(FUNC_TICK, 1'b0, 1'b0, 16'h0000, LANES_BOTH);
      issue_request(FUNC_TICK, 1'b0, 1'b0, 16'h0000, LANES_BOTH);
      issue_request(FUNC_TICK, 1'b0, 1'b0, 16'h0000, LANES_BOTH);
      issue_request(FUNC_TICK, 1'b0, 1'b0, 16'h0000, LANES_BOTH);
      issue_request(FUNC_READ_CTL, 1'b0, 1'b0, 16'h0000, LANES_NONE);
      // uf written as one leaves the flag, then a clear edge drops it
      issue_request(FUNC_WRITE_CTL, 1'b0, 1'b0,
                    ctl_word(CSL_PRE2, MODE_SOFT, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0),
                    LANES_LOW);
      issue_request(FUNC_TICK, 1'b0, 1'b1, 16'h0000, LANES_BOTH);
      issue_request(FUNC_READ_CNT, 1'b0, 1'b0, 16'h0000, LANES_HIGH);
      // high byte only: external clock on falling tin, trg in the low byte ignored
      issue_request(FUNC_WRITE_CTL, 1'b0, 1'b0,
                    ctl_word(CSL_EXT, {1'b0, EDGE_FALL}, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0,
                             1'b1, 1'b1), LANES_HIGH);
      issue_request(FUNC_TICK, 1'b1, 1'b0, 16'h0000, LANES_BOTH);
      issue_request(FUNC_TICK, 1'b0, 1'b0, 16'h0000, LANES_BOTH);
      // clearing cnte stops the counter where it is
      issue_request(FUNC_WRITE_CTL, 1'b0, 1'b0, 16'h0000, LANES_LOW);
      issue_request(FUNC_READ_CNT, 1'b0, 1'b0, 16'h0000, LANES_BOTH);

      base = requests_sent;
      while (requests_sent - base < RandomItems) begin
         steady = (requests_sent - base >= SteadyFirst) && (requests_sent - base < SteadyLast);
         if ($urandom_range(99, 0) < 15) begin
            repeat ($urandom_range(8, 1)) begin
               issue_request(3'($urandom_range(7, 0)), 1'($urandom_range(1, 0)),
                             1'($urandom_range(1, 0)), 16'($urandom),
                             2'($urandom_range(3, 0)));
            end
         end else begin
            // small reloads keep underflows frequent
            data_pick = ($urandom_range(9, 0) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(12, 0));
            issue_request(FUNC_WRITE_RELD, tin_now, clr_now, data_pick, LANES_BOTH);
            data_pick = ctl_word(2'($urandom_range(3, 0)), 3'($urandom_range(7, 0)),
                                 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)),
                                 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)),
                                 1'($urandom_range(1, 0)), $urandom_range(9, 0) != 0,
                                 $urandom_range(4, 0) != 0)
                        | {4'($urandom_range(15, 0)), 12'h000};
            lanes_pick = ($urandom_range(9, 0) == 0) ? 2'($urandom_range(3, 0)) : LANES_BOTH;
            issue_request(FUNC_WRITE_CTL, tin_now, clr_now, data_pick, lanes_pick);
            repeat ($urandom_range(60, 10)) begin
               if ($urandom_range(3, 0) == 0) tin_now = ~tin_now;
               if ($urandom_range(9, 0) == 0) clr_now = ~clr_now;
               pick = $urandom_range(99, 0);
               if (pick < 70) func_pick = FUNC_TICK;
               else if (pick < 78) func_pick = FUNC_READ_CTL;
               else if (pick < 86) func_pick = FUNC_READ_CNT;
               else if (pick < 90)
                  func_pick = 3'($urandom_range(FUNC_UNUSED_LAST, FUNC_UNUSED_FIRST));
               else if (pick < 95) func_pick = FUNC_WRITE_CTL;
               else func_pick = FUNC_WRITE_RELD;
               issue_request(func_pick, tin_now, clr_now, 16'($urandom),
                             2'($urandom_range(3, 0)));
            end
         end
      end
      steady    = 1'b0;
      req_valid = 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (fail_total == 0) begin
         $display("reload_timer_16bit_core: match");
      end else begin
         $display("reload_timer_16bit_core: mismatch");
      end
      $finish;
   end

endmodule
